>>> sv/wsfd_pkg.sv
`default_nettype none

package wsfd_pkg;

  // Default width of the frame length counter.
  localparam int unsigned LENGTH_BITS_DEF = 64;

  // Header length codes and byte counts.
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [2:0] KEY_BYTES    = 3'd4;

  // Opcodes that the deframer acts on.
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  // Status codes on the result.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MSG    = 2'd1;
  localparam logic [1:0] ST_BINARY    = 2'd2;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  // One result beat.
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  payload_byte;
    logic [3:0]  message_opcode;
    logic        end_of_message;
    logic [1:0]  status;
    logic        pong_request;
    logic [15:0] close_code;
  } result_t;

endpackage

`default_nettype wire

>>> sv/wsfd_core.sv
`default_nettype none

module wsfd_core #(
  parameter int unsigned LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        rx_byte,
  output logic                   res_valid,
  output wsfd_pkg::result_t      res
);

  wsfd_pkg::phase_t         phase_r, phase_nxt;
  logic                     frame_final_r, frame_final_nxt;
  logic                     frame_masked_r, frame_masked_nxt;
  logic [3:0]               open_opcode_r, open_opcode_nxt;
  logic                     message_open_r, message_open_nxt;
  logic [3:0]               len_left_r, len_left_nxt;
  logic [2:0]               key_left_r, key_left_nxt;
  logic [31:0]              mask_key_r, mask_key_nxt;
  logic [LENGTH_BITS-1:0]   bytes_rem_r, bytes_rem_nxt;
  logic [1:0]               key_index_r, key_index_nxt;
  logic [15:0]              close_value_r, close_value_nxt;
  logic [1:0]               msg_count_r, msg_count_nxt;

  logic                     do_after_len;
  logic                     do_start;
  logic                     do_end;
  logic                     end_has;
  logic [7:0]               end_byte;
  logic [7:0]               unmasked;
  logic [3:0]               hdr_op;
  logic [6:0]               hdr_len;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= wsfd_pkg::PH_HDR1;
      frame_final_r  <= 1'b0;
      frame_masked_r <= 1'b0;
      open_opcode_r  <= wsfd_pkg::OP_CONT;
      message_open_r <= 1'b0;
      len_left_r     <= '0;
      key_left_r     <= '0;
      mask_key_r     <= '0;
      bytes_rem_r    <= '0;
      key_index_r    <= '0;
      close_value_r  <= '0;
      msg_count_r    <= '0;
    end else begin
      phase_r        <= phase_nxt;
      frame_final_r  <= frame_final_nxt;
      frame_masked_r <= frame_masked_nxt;
      open_opcode_r  <= open_opcode_nxt;
      message_open_r <= message_open_nxt;
      len_left_r     <= len_left_nxt;
      key_left_r     <= key_left_nxt;
      mask_key_r     <= mask_key_nxt;
      bytes_rem_r    <= bytes_rem_nxt;
      key_index_r    <= key_index_nxt;
      close_value_r  <= close_value_nxt;
      msg_count_r    <= msg_count_nxt;
    end
  end

  assign hdr_op  = rx_byte[3:0];
  assign hdr_len = rx_byte[6:0];

  // Payload byte unmasked by the key byte in turn, first key byte in the top bits.
  assign unmasked = rx_byte ^ 8'(mask_key_r >> {~key_index_r, 3'b000});

  // Next state and result for one accepted byte.
  always_comb begin
    phase_nxt        = phase_r;
    frame_final_nxt  = frame_final_r;
    frame_masked_nxt = frame_masked_r;
    open_opcode_nxt  = open_opcode_r;
    message_open_nxt = message_open_r;
    len_left_nxt     = len_left_r;
    key_left_nxt     = key_left_r;
    mask_key_nxt     = mask_key_r;
    bytes_rem_nxt    = bytes_rem_r;
    key_index_nxt    = key_index_r;
    close_value_nxt  = close_value_r;
    msg_count_nxt    = msg_count_r;
    res_valid        = 1'b0;
    res              = '0;
    do_after_len     = 1'b0;
    do_start         = 1'b0;
    do_end           = 1'b0;
    end_has          = 1'b0;
    end_byte         = '0;

    if (step) begin
      case (phase_r)
        wsfd_pkg::PH_HDR1: begin
          if (hdr_op == wsfd_pkg::OP_CONT && !message_open_r) begin
            // Continuation with nothing open: report it and return to reset state.
            res_valid        = 1'b1;
            res.status       = wsfd_pkg::ST_NO_MSG;
            phase_nxt        = wsfd_pkg::PH_HDR1;
            frame_final_nxt  = 1'b0;
            frame_masked_nxt = 1'b0;
            open_opcode_nxt  = wsfd_pkg::OP_CONT;
            message_open_nxt = 1'b0;
            len_left_nxt     = '0;
            key_left_nxt     = '0;
            mask_key_nxt     = '0;
            bytes_rem_nxt    = '0;
            key_index_nxt    = '0;
            close_value_nxt  = '0;
            msg_count_nxt    = '0;
          end else begin
            frame_final_nxt = rx_byte[7];
            if (hdr_op != wsfd_pkg::OP_CONT) begin
              open_opcode_nxt = hdr_op;
              msg_count_nxt   = '0;
              close_value_nxt = '0;
            end
            message_open_nxt = 1'b1;
            phase_nxt        = wsfd_pkg::PH_HDR2;
          end
        end
        wsfd_pkg::PH_HDR2: begin
          frame_masked_nxt = rx_byte[7];
          mask_key_nxt     = '0;
          key_index_nxt    = '0;
          key_left_nxt     = '0;
          bytes_rem_nxt    = '0;
          if (hdr_len < wsfd_pkg::LEN_EXT16) begin
            bytes_rem_nxt = LENGTH_BITS'(hdr_len);
            len_left_nxt  = '0;
            do_after_len  = 1'b1;
          end else begin
            len_left_nxt = (hdr_len == wsfd_pkg::LEN_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                             : wsfd_pkg::EXT64_BYTES;
            phase_nxt    = wsfd_pkg::PH_EXTLEN;
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          // Extended length arrives most significant byte first; excess bits wrap.
          bytes_rem_nxt = {bytes_rem_r[LENGTH_BITS-9:0], rx_byte};
          len_left_nxt  = (len_left_r != '0) ? len_left_r - 4'd1 : len_left_r;
          if (len_left_nxt == '0) begin
            do_after_len = 1'b1;
          end
        end
        wsfd_pkg::PH_KEY: begin
          mask_key_nxt = {mask_key_r[23:0], rx_byte};
          key_left_nxt = (key_left_r != '0) ? key_left_r - 3'd1 : key_left_r;
          if (key_left_nxt == '0) begin
            do_start = 1'b1;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          key_index_nxt = key_index_r + 2'd1;
          // The first two bytes of a message form the close code.
          if (msg_count_r == 2'd0) begin
            close_value_nxt = {unmasked, 8'h00};
            msg_count_nxt   = 2'd1;
          end else if (msg_count_r == 2'd1) begin
            close_value_nxt = {close_value_r[15:8], unmasked};
            msg_count_nxt   = 2'd2;
          end
          bytes_rem_nxt = (bytes_rem_r != '0) ? bytes_rem_r - LENGTH_BITS'(1) : bytes_rem_r;
          if (bytes_rem_nxt == '0) begin
            do_end   = 1'b1;
            end_has  = 1'b1;
            end_byte = unmasked;
          end else begin
            res_valid          = 1'b1;
            res.has_byte       = 1'b1;
            res.payload_byte   = unmasked;
            res.message_opcode = open_opcode_r;
          end
        end
        default: begin
          phase_nxt = wsfd_pkg::PH_HDR1;
        end
      endcase
    end

    // Length known: a masked frame collects its key next.
    if (do_after_len) begin
      if (frame_masked_nxt) begin
        key_left_nxt = wsfd_pkg::KEY_BYTES;
        phase_nxt    = wsfd_pkg::PH_KEY;
      end else begin
        do_start = 1'b1;
      end
    end

    // Header done: an empty frame ends at once.
    if (do_start) begin
      if (bytes_rem_nxt == '0) begin
        do_end = 1'b1;
      end else begin
        phase_nxt = wsfd_pkg::PH_PAYLOAD;
      end
    end

    // End of frame, and of the message when the frame is final.
    if (do_end) begin
      phase_nxt = wsfd_pkg::PH_HDR1;
      if (!frame_final_r) begin
        if (end_has) begin
          res_valid          = 1'b1;
          res.has_byte       = 1'b1;
          res.payload_byte   = end_byte;
          res.message_opcode = open_opcode_r;
        end
      end else begin
        res_valid          = 1'b1;
        res.has_byte       = end_has;
        res.payload_byte   = end_byte;
        res.message_opcode = open_opcode_r;
        res.end_of_message = 1'b1;
        res.status         = (open_opcode_r == wsfd_pkg::OP_BINARY) ? wsfd_pkg::ST_BINARY
                                                                    : wsfd_pkg::ST_OK;
        res.pong_request   = (open_opcode_r == wsfd_pkg::OP_PING);
        res.close_code     = (open_opcode_r == wsfd_pkg::OP_CLOSE) ? close_value_nxt
                                                                   : 16'h0000;
        message_open_nxt   = 1'b0;
        msg_count_nxt      = '0;
        close_value_nxt    = '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/websocket_frame_deframer.sv
`default_nettype none

// Receive-side websocket frame deframer. It takes one received byte per beat
// and walks the frame header, the 16- or 64-bit extended length, the optional
// mask key and the payload, giving one result beat per payload byte (unmasked
// and tagged with the message opcode) and a bare end beat for an empty final
// frame. Header bytes give no result, but for an orphan continuation header,
// which gives a bare error beat. A byte is taken every clock when the output
// side keeps up; its result is registered when the byte is accepted, and a new
// byte can be taken in the same cycle that a waiting result is delivered.
// While a result waits and the output side holds off, the input is stalled.
// The clock rate is set by the length counter decrement and its zero test,
// LENGTH_BITS wide, between the input port and the state registers.
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_has_byte,
  output logic [7:0]       out_payload_byte,
  output logic [3:0]       out_message_opcode,
  output logic             out_end_of_message,
  output logic [1:0]       out_status,
  output logic             out_pong_request,
  output logic [15:0]      out_close_code
);

  logic               in_accept;
  logic               res_valid;
  wsfd_pkg::result_t  res;
  logic               out_valid_r, out_valid_nxt;
  wsfd_pkg::result_t  out_r, out_nxt;

  // A byte is taken whenever the output register is free or being emptied.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  wsfd_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_accept),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (in_accept && res_valid) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_has_byte       = out_r.has_byte;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_message_opcode = out_r.message_opcode;
  assign out_end_of_message = out_r.end_of_message;
  assign out_status         = out_r.status;
  assign out_pong_request   = out_r.pong_request;
  assign out_close_code     = out_r.close_code;

  // The error beat carries nothing but its status.
  a_err_bare: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == wsfd_pkg::ST_NO_MSG) |->
      (!out_has_byte && out_message_opcode == wsfd_pkg::OP_CONT && !out_end_of_message))
    else $error("error beat carries payload");

  // A pong request only comes at the end of a ping message.
  a_pong_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pong_request) |->
      (out_end_of_message && out_message_opcode == wsfd_pkg::OP_PING))
    else $error("pong request outside ping message end");

  // An empty beat never shows payload data.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_byte) |-> (out_payload_byte == 8'h00))
    else $error("payload byte set on empty beat");

  // A close code only appears on the end of a close message.
  a_close_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_close_code != 16'h0000) |->
      (out_end_of_message && out_message_opcode == wsfd_pkg::OP_CLOSE))
    else $error("close code outside close message end");

endmodule

`default_nettype wire

>>> verif/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

  // Opcodes that the package does not name.
  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_PONG = 4'hA;

  // Only the low length bits of an extended length are kept.
  localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - wsfd_pkg::LENGTH_BITS_DEF);

  localparam int RANDOM_BYTES = 1250;
  localparam int HOLD_CYCLES  = 250;
  localparam int TAIL_CYCLES  = 16;

  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  // Frame parser mirror: follows the received bytes and queues the beats that the
  // deframer must give, then checks each delivered beat against the oldest one.
  class ws_deframe_model;
    wsfd_pkg::phase_t  stage;
    logic              last_frame;
    logic              masked_frame;
    logic [3:0]        msg_opcode;
    logic              msg_open;
    logic [3:0]        len_bytes_due;
    logic [2:0]        key_bytes_due;
    logic [31:0]       key_word;
    logic [63:0]       payload_left;
    logic [1:0]        key_pos;
    logic [15:0]       close_word;
    logic [1:0]        bytes_seen;
    wsfd_pkg::result_t pending_beats[$];
    int                mismatches;
    int                bytes_taken;
    int                beats_checked;
    int                message_ends;
    int                orphans;

    function new();
      clear();
    endfunction

    function void clear();
      stage         = wsfd_pkg::PH_HDR1;
      last_frame    = 1'b0;
      masked_frame  = 1'b0;
      msg_opcode    = wsfd_pkg::OP_CONT;
      msg_open      = 1'b0;
      len_bytes_due = '0;
      key_bytes_due = '0;
      key_word      = '0;
      payload_left  = '0;
      key_pos       = '0;
      close_word    = '0;
      bytes_seen    = '0;
    endfunction

    function void queue_beat(logic has, logic [7:0] data, logic [3:0] op, logic eom,
                             logic [1:0] st, logic pong, logic [15:0] code);
      wsfd_pkg::result_t r;
      r.has_byte       = has;
      r.payload_byte   = data;
      r.message_opcode = op;
      r.end_of_message = eom;
      r.status         = st;
      r.pong_request   = pong;
      r.close_code     = code;
      pending_beats.push_back(r);
      if (eom) message_ends++;
    endfunction

    // End of a frame: a non-final frame only passes its last byte on, a final one
    // closes the message with its end actions.
    function void finish_frame(logic has, logic [7:0] data);
      stage = wsfd_pkg::PH_HDR1;
      if (!last_frame) begin
        if (has) queue_beat(1'b1, data, msg_opcode, 1'b0, wsfd_pkg::ST_OK, 1'b0, 16'h0);
        return;
      end
      queue_beat(has, has ? data : 8'h00, msg_opcode, 1'b1,
                 (msg_opcode == wsfd_pkg::OP_BINARY) ? wsfd_pkg::ST_BINARY
                                                     : wsfd_pkg::ST_OK,
                 msg_opcode == wsfd_pkg::OP_PING,
                 (msg_opcode == wsfd_pkg::OP_CLOSE) ? close_word : 16'h0);
      msg_open   = 1'b0;
      bytes_seen = '0;
      close_word = '0;
    endfunction

    function void begin_payload();
      if (payload_left == 0) finish_frame(1'b0, 8'h00);
      else stage = wsfd_pkg::PH_PAYLOAD;
    endfunction

    function void length_done();
      if (masked_frame) begin
        key_bytes_due = wsfd_pkg::KEY_BYTES;
        stage = wsfd_pkg::PH_KEY;
      end else begin
        begin_payload();
      end
    endfunction

    function void take_byte(logic [7:0] b);
      logic [7:0] plain;
      bytes_taken++;
      case (stage)
        wsfd_pkg::PH_HDR1: begin
          if (b[3:0] == wsfd_pkg::OP_CONT && !msg_open) begin
            // A continuation with nothing to continue: error beat and full reset.
            queue_beat(1'b0, 8'h00, wsfd_pkg::OP_CONT, 1'b0, wsfd_pkg::ST_NO_MSG,
                       1'b0, 16'h0);
            orphans++;
            clear();
          end else begin
            last_frame = b[7];
            if (b[3:0] != wsfd_pkg::OP_CONT) begin
              msg_opcode = b[3:0];
              bytes_seen = '0;
              close_word = '0;
            end
            msg_open = 1'b1;
            stage = wsfd_pkg::PH_HDR2;
          end
        end
        wsfd_pkg::PH_HDR2: begin
          masked_frame  = b[7];
          key_word      = '0;
          key_pos       = '0;
          key_bytes_due = '0;
          payload_left  = '0;
          if (b[6:0] < wsfd_pkg::LEN_EXT16) begin
            payload_left  = {57'h0, b[6:0]} & LEN_MASK;
            len_bytes_due = '0;
            length_done();
          end else begin
            len_bytes_due = (b[6:0] == wsfd_pkg::LEN_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                            : wsfd_pkg::EXT64_BYTES;
            stage = wsfd_pkg::PH_EXTLEN;
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          payload_left = ((payload_left << 8) | {56'h0, b}) & LEN_MASK;
          if (len_bytes_due != 0) len_bytes_due--;
          if (len_bytes_due == 0) length_done();
        end
        wsfd_pkg::PH_KEY: begin
          key_word = {key_word[23:0], b};
          if (key_bytes_due != 0) key_bytes_due--;
          if (key_bytes_due == 0) begin_payload();
        end
        wsfd_pkg::PH_PAYLOAD: begin
          // The key rotates from its most significant byte downwards.
          plain = b ^ key_word[8 * (3 - key_pos) +: 8];
          key_pos++;
          if (bytes_seen == 0) begin
            close_word = {plain, 8'h00};
            bytes_seen = 2'd1;
          end else if (bytes_seen == 1) begin
            close_word[7:0] = plain;
            bytes_seen = 2'd2;
          end
          if (payload_left != 0) payload_left--;
          if (payload_left == 0) finish_frame(1'b1, plain);
          else queue_beat(1'b1, plain, msg_opcode, 1'b0, wsfd_pkg::ST_OK, 1'b0, 16'h0);
        end
        default: stage = wsfd_pkg::PH_HDR1;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] deframer mismatch: %s", $time, what);
    endtask

    task check_field(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("beat %0d %s got %0h, wanted %0h",
                                  beats_checked, field, got, want));
    endtask

    task check_beat(wsfd_pkg::result_t got);
      wsfd_pkg::result_t want;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("beat %0h arrived with nothing outstanding", got));
        return;
      end
      want = pending_beats.pop_front();
      beats_checked++;
      check_field("has_byte", 16'(got.has_byte), 16'(want.has_byte));
      check_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
      check_field("message_opcode", 16'(got.message_opcode), 16'(want.message_opcode));
      check_field("end_of_message", 16'(got.end_of_message), 16'(want.end_of_message));
      check_field("status", 16'(got.status), 16'(want.status));
      check_field("pong_request", 16'(got.pong_request), 16'(want.pong_request));
      check_field("close_code", got.close_code, want.close_code);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_has_byte;
  logic [7:0]  out_payload_byte;
  logic [3:0]  out_message_opcode;
  logic        out_end_of_message;
  logic [1:0]  out_status;
  logic        out_pong_request;
  logic [15:0] out_close_code;

  ws_deframe_model model = new();

  // Sender and receiver idling controls; each has a single writer.
  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;
  int hold_asks  = 0;
  int holds_done = 0;
  bit open_msg   = 1'b0;
  int bytes_driven = 0;

  always #1 clk = ~clk;

  websocket_frame_deframer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_has_byte       (out_has_byte),
    .out_payload_byte   (out_payload_byte),
    .out_message_opcode (out_message_opcode),
    .out_end_of_message (out_end_of_message),
    .out_status         (out_status),
    .out_pong_request   (out_pong_request),
    .out_close_code     (out_close_code)
  );

  // Watch both channels: accepted bytes feed the mirror, delivered beats are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) model.take_byte(in_rx_byte);
      if (out_valid && out_ready)
        model.check_beat(wsfd_pkg::result_t'({out_has_byte, out_payload_byte,
                                              out_message_opcode, out_end_of_message,
                                              out_status, out_pong_request,
                                              out_close_code}));
    end
  end

  // Offer one byte, after a random gap unless in a burst, and wait for it to be taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_driven++;
  endtask

  // One well-formed frame with random reserved bits, key and payload.
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input len_form_t form, input logic [63:0] plen);
    logic [31:0] key;
    key = $urandom;
    send_byte({fin, 3'($urandom), op});
    case (form)
      FORM_SHORT: send_byte({masked, plen[6:0]});
      FORM_EXT16: begin
        send_byte({masked, wsfd_pkg::LEN_EXT16});
        send_byte(plen[15:8]);
        send_byte(plen[7:0]);
      end
      default: begin
        send_byte({masked, wsfd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(plen[8 * i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    for (longint unsigned n = 0; n < plen; n++) send_byte(8'($urandom));
    open_msg = !fin;
  endtask

  // Stop offering bytes and wait until every expected beat has been delivered.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.pending_beats.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls per beat, occasional long hold-offs on request.
  initial begin : receiver
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done < hold_asks) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    logic [7:0]  directed_bytes[$];
    int          frame_no;
    int          r;
    logic [3:0]  op;
    logic [63:0] plen;
    len_form_t   form;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames: orphan continuation, empty final ping, binary end with an
    // all-ones byte, masked non-final text then an empty final continuation,
    // a short close through a 16-bit length, and a reserved opcode of zero length.
    directed_bytes = '{8'h80,
                       8'h89, 8'h00,
                       8'h82, 8'h01, 8'hFF,
                       8'h01, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'h53,
                       8'hF0, 8'h00,
                       8'h88, 8'h7E, 8'h00, 8'h01, 8'h03,
                       8'h8F, 8'h7E, 8'h00, 8'h00};
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    open_msg = 1'b0;
    wait_for_drain();

    // Random frames, mostly well formed, with orphan continuations as noise.
    frame_no = 0;
    while (bytes_driven < RANDOM_BYTES + directed_bytes.size()) begin
      frame_no++;
      if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
      if (frame_no % 40 == 3) begin
        // Long hold-off at the receiver while a long frame keeps arriving.
        hold_asks++;
        send_frame(1'b1, OP_TEXT, 1'b1, FORM_EXT16, 64'd200);
      end else if (frame_no % 25 == 0) begin
        wait_for_drain();
      end else if (!open_msg && $urandom_range(0, 9) == 0) begin
        send_byte({1'($urandom), 3'($urandom), wsfd_pkg::OP_CONT});
      end else begin
        if (open_msg && $urandom_range(0, 1) == 1) begin
          op = wsfd_pkg::OP_CONT;
        end else begin
          case ($urandom_range(0, 7))
            0, 1:    op = OP_TEXT;
            2:       op = wsfd_pkg::OP_BINARY;
            3:       op = wsfd_pkg::OP_CLOSE;
            4:       op = wsfd_pkg::OP_PING;
            5:       op = OP_PONG;
            default: op = 4'($urandom_range(1, 15));
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
          form = FORM_SHORT;
          plen = 64'($urandom_range(0, 8));
        end else if (r < 72) begin
          form = FORM_SHORT;
          plen = 64'($urandom_range(0, 125));
        end else if (r < 84) begin
          form = FORM_EXT16;
          plen = 64'($urandom_range(0, 40));
        end else if (r < 88) begin
          form = FORM_EXT16;
          plen = 64'($urandom_range(126, 300));
        end else begin
          form = FORM_EXT64;
          plen = 64'($urandom_range(0, 40));
        end
        send_frame($urandom_range(0, 9) < 7, op, 1'($urandom), form, plen);
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d received bytes and %0d checked beats,",
             model.bytes_taken, model.beats_checked);
    $display("including %0d message ends and %0d orphan continuations.",
             model.message_ends, model.orphans);
    if (model.mismatches == 0) begin
      $display("websocket_frame_deframer regression: pass");
    end else begin
      $display("websocket_frame_deframer regression: fail");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin : watchdog
    #1000000;
    $display("Run timed out with %0d beats outstanding.", model.pending_beats.size());
    $display("websocket_frame_deframer regression: fail");
    $finish;
  end

endmodule
